>>> design/lcdseq_pkg.sv
// Shared types, register indexes and init-sequence table for the LCD write sequencer.
package lcdseq_pkg;

    // Item kinds
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_CMD    = 3'd1;
    localparam logic [2:0] KIND_DATA   = 3'd2;
    localparam logic [2:0] KIND_CURSOR = 3'd3;
    localparam logic [2:0] KIND_INIT   = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_STROBE_TIME     = 3'd0;
    localparam logic [2:0] CFG_CONTROL_WAIT    = 3'd1;
    localparam logic [2:0] CFG_CLEAR_WAIT      = 3'd2;
    localparam logic [2:0] CFG_INIT_LONG_WAIT  = 3'd3;
    localparam logic [2:0] CFG_INIT_SHORT_WAIT = 3'd4;

    // Configuration reset values (microseconds)
    localparam logic [15:0] RST_STROBE_TIME     = 16'd1;
    localparam logic [15:0] RST_CONTROL_WAIT    = 16'd39;
    localparam logic [15:0] RST_CLEAR_WAIT      = 16'd1530;
    localparam logic [15:0] RST_INIT_LONG_WAIT  = 16'd4100;
    localparam logic [15:0] RST_INIT_SHORT_WAIT = 16'd100;

    // LCD command bytes
    localparam logic [7:0] LCD_SET_DDRAM   = 8'h80;
    localparam logic [7:0] LCD_ROW1_OFFSET = 8'h40;
    localparam logic [7:0] LCD_CMD_CLR     = 8'h01;
    localparam logic [7:0] LCD_HOME        = 8'h02;
    localparam logic [7:0] LCD_DISPLAY_ON  = 8'h08 | 8'h06;
    localparam logic [7:0] LCD_ENTRY_MODE  = 8'h04 | 8'h02;
    localparam logic [7:0] LCD_NIB_8BIT    = 8'h03;
    localparam logic [7:0] LCD_NIB_4BIT    = 8'h02;

    // Number of steps in the power-up sequence
    localparam logic [2:0] INIT_LAST = 3'd7;

    typedef enum logic [1:0] {
        W_CTRL,
        W_CLEAR,
        W_LONG,
        W_SHORT
    } t_wait_sel;

    typedef struct packed {
        logic      single_nibble;
        logic [7:0] value;
        t_wait_sel wait_sel;
    } t_init_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_value;
        logic [5:0] column;
        logic [1:0] row;
    } t_in_item;

    typedef struct packed {
        logic       reg_select;
        logic       read_write;
        logic       enable;
        logic [3:0] data_nibble;
        logic       busy_res;
        logic       dropped;
    } t_out_item;

    function automatic t_init_item init_item(input logic [2:0] idx);
        t_init_item it;
        case (idx)
            3'd0:    it = '{1'b1, LCD_NIB_8BIT,   W_LONG};
            3'd1:    it = '{1'b1, LCD_NIB_4BIT,   W_SHORT};
            3'd2:    it = '{1'b1, LCD_NIB_4BIT,   W_CTRL};
            3'd3:    it = '{1'b0, LCD_DISPLAY_ON, W_CTRL};
            3'd4:    it = '{1'b0, LCD_CMD_CLR,    W_CLEAR};
            3'd5:    it = '{1'b0, LCD_ENTRY_MODE, W_CTRL};
            3'd6:    it = '{1'b0, LCD_HOME,       W_CLEAR};
            default: it = '{1'b0, 8'h00,          W_CTRL};
        endcase
        return it;
    endfunction

endpackage

>>> design/char_lcd_4bit_write_sequencer.sv
// Top level of the character LCD 4-bit write sequencer.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready  | t_in_item: kind, byte, col, row
//  out     | output    | o_out_valid / i_out_ready| t_out_item: pins, busy, dropped
//  cfg     | input     | i_cfg_we (no wait)       | i_cfg_index, i_cfg_data
//
// Each item waits in the input register and is applied to the sequencer
// state in the cycle it moves to the result register; one item per cycle is
// sustained unless the output stalls, set by the single state-update step.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle, pins low and
// configuration to its defaults. A stall on the output holds the result register
// and the input register; the input side keeps taking a transfer while the
// input register is empty.
module char_lcd_4bit_write_sequencer
    import lcdseq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HI_ON,
        PH_HI_OFF,
        PH_LO_ON,
        PH_LO_OFF,
        PH_POST
    } t_phase;

    // Configuration
    logic [15:0] r_strobe, r_ctrl_wait, r_clear_wait, r_long_wait, r_short_wait;

    // Input register
    logic       r_in_valid;
    t_in_item   r_in;

    // Result register
    logic       r_out_valid;
    t_out_item  r_out;

    // Sequencer state
    t_phase     r_phase, n_phase;
    logic [15:0] r_wait, n_wait;
    logic [7:0] r_byte, n_byte;
    logic       r_sel, n_sel;
    logic [2:0] r_step, n_step;
    logic       r_rs, n_rs;
    logic       r_en, n_en;
    logic [3:0] r_nib, n_nib;

    logic       advance;
    logic       dropped;
    logic       busy;
    logic       is_request;
    logic [15:0] strobe_len;
    logic [15:0] post_len;
    logic [15:0] wait_dec;
    logic [7:0] ddram_addr;
    t_wait_sel  post_sel;
    t_init_item init_now;
    t_init_item init_done;
    t_init_item init_first;
    logic       st_go, st_single, st_rs, fin;
    logic [7:0] st_val;

    // Move an item into the result register when the result slot frees up.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign busy       = (r_phase != PH_IDLE);
    assign is_request = r_in.kind inside {KIND_CMD, KIND_DATA, KIND_CURSOR, KIND_INIT};
    // A strobe time of zero behaves as one microsecond.
    assign strobe_len = (r_strobe == 16'd0) ? 16'd1 : r_strobe;
    assign wait_dec   = r_wait - 16'd1;

    // Init step k (1..7) is running item k-1 of the table.
    assign init_done  = init_item(r_step - 3'd1);
    assign init_now   = init_item(r_step);
    assign init_first = init_item(3'd0);

    always_comb begin
        if (r_step != 3'd0) begin
            post_sel = init_done.wait_sel;
        end else if (!r_sel && (r_byte == LCD_CMD_CLR || r_byte == LCD_HOME)) begin
            post_sel = W_CLEAR;
        end else begin
            post_sel = W_CTRL;
        end
        case (post_sel)
            W_CLEAR: post_len = r_clear_wait;
            W_LONG:  post_len = r_long_wait;
            W_SHORT: post_len = r_short_wait;
            default: post_len = r_ctrl_wait;
        endcase
    end

    // Row 0 maps straight to column, row 1 adds the second-line offset, others to zero.
    always_comb begin
        case (r_in.row)
            2'd0:    ddram_addr = {2'b00, r_in.column};
            2'd1:    ddram_addr = LCD_ROW1_OFFSET | {2'b00, r_in.column};
            default: ddram_addr = 8'h00;
        endcase
    end

    // Apply one item to the sequencer state.
    always_comb begin
        n_phase   = r_phase;
        n_wait    = r_wait;
        n_byte    = r_byte;
        n_sel     = r_sel;
        n_step    = r_step;
        n_rs      = r_rs;
        n_en      = r_en;
        n_nib     = r_nib;
        dropped   = 1'b0;
        st_go     = 1'b0;
        st_single = 1'b0;
        st_rs     = 1'b0;
        st_val    = 8'h00;
        fin       = 1'b0;

        if (is_request) begin
            if (busy) begin
                // Drop the request; time does not advance.
                dropped = 1'b1;
            end else begin
                st_go = 1'b1;
                case (r_in.kind)
                    KIND_CMD: begin
                        st_val = r_in.byte_value;
                    end
                    KIND_DATA: begin
                        st_rs  = 1'b1;
                        st_val = r_in.byte_value;
                    end
                    KIND_CURSOR: begin
                        st_val = LCD_SET_DDRAM | ddram_addr;
                    end
                    default: begin
                        // Power-up sequence: start table item 0.
                        n_step    = 3'd1;
                        st_single = init_first.single_nibble;
                        st_val    = init_first.value;
                    end
                endcase
            end
        end else if (busy) begin
            // Tick: count down, then step to the next phase.
            if (wait_dec != 16'd0) begin
                n_wait = wait_dec;
            end else begin
                case (r_phase)
                    PH_HI_ON: begin
                        n_en    = 1'b0;
                        n_phase = PH_HI_OFF;
                        n_wait  = strobe_len;
                    end
                    PH_HI_OFF: begin
                        n_rs    = r_sel;
                        n_en    = 1'b1;
                        n_nib   = r_byte[3:0];
                        n_phase = PH_LO_ON;
                        n_wait  = strobe_len;
                    end
                    PH_LO_ON: begin
                        n_en    = 1'b0;
                        n_phase = PH_LO_OFF;
                        n_wait  = strobe_len;
                    end
                    PH_LO_OFF: begin
                        if (post_len == 16'd0) begin
                            fin = 1'b1;
                        end else begin
                            n_phase = PH_POST;
                            n_wait  = post_len;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
        end

        // End of a byte: continue the init sequence or go idle.
        if (fin) begin
            if (r_step != 3'd0 && r_step != INIT_LAST) begin
                n_step    = r_step + 3'd1;
                st_go     = 1'b1;
                st_single = init_now.single_nibble;
                st_val    = init_now.value;
            end else begin
                n_step  = 3'd0;
                n_phase = PH_IDLE;
                n_wait  = 16'd0;
            end
        end

        // Start a byte (high nibble first) or a lone nibble.
        if (st_go) begin
            n_wait = strobe_len;
            n_en   = 1'b1;
            if (st_single) begin
                n_byte  = {4'h0, st_val[3:0]};
                n_sel   = 1'b0;
                n_rs    = 1'b0;
                n_nib   = st_val[3:0];
                n_phase = PH_LO_ON;
            end else begin
                n_byte  = st_val;
                n_sel   = st_rs;
                n_rs    = st_rs;
                n_nib   = st_val[7:4];
                n_phase = PH_HI_ON;
            end
        end
    end

    // Input register payload: load on every input transfer.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    // State, configuration and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe     <= RST_STROBE_TIME;
            r_ctrl_wait  <= RST_CONTROL_WAIT;
            r_clear_wait <= RST_CLEAR_WAIT;
            r_long_wait  <= RST_INIT_LONG_WAIT;
            r_short_wait <= RST_INIT_SHORT_WAIT;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out        <= '0;
            r_phase      <= PH_IDLE;
            r_wait       <= 16'd0;
            r_byte       <= 8'h00;
            r_sel        <= 1'b0;
            r_step       <= 3'd0;
            r_rs         <= 1'b0;
            r_en         <= 1'b0;
            r_nib        <= 4'h0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STROBE_TIME:     r_strobe     <= i_cfg_data;
                    CFG_CONTROL_WAIT:    r_ctrl_wait  <= i_cfg_data;
                    CFG_CLEAR_WAIT:      r_clear_wait <= i_cfg_data;
                    CFG_INIT_LONG_WAIT:  r_long_wait  <= i_cfg_data;
                    CFG_INIT_SHORT_WAIT: r_short_wait <= i_cfg_data;
                    default: ;
                endcase
            end

            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end

            if (advance) begin
                r_out_valid       <= 1'b1;
                r_out.reg_select  <= n_rs;
                r_out.read_write  <= 1'b0;
                r_out.enable      <= n_en;
                r_out.data_nibble <= n_nib;
                r_out.busy_res    <= (n_phase != PH_IDLE);
                r_out.dropped     <= dropped;
                r_phase           <= n_phase;
                r_wait            <= n_wait;
                r_byte            <= n_byte;
                r_sel             <= n_sel;
                r_step            <= n_step;
                r_rs              <= n_rs;
                r_en              <= n_en;
                r_nib             <= n_nib;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A dropped request leaves the sequencer busy.
    a_drop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.dropped) |-> o_out.busy_res)
        else $error("dropped result without busy");

    // Enable is low and no init step is pending while idle.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (!r_en && r_step == 3'd0))
        else $error("idle with enable high or init step pending");

    // An active phase always has time left to count.
    a_wait_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_wait != 16'd0))
        else $error("active phase with zero wait count");

    // The state moves only when an item is applied.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_phase) && $stable(r_wait))
        else $error("sequencer state changed without an item");

endmodule
